### hw/rtl/crst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crst_pkg: shared types and helpers for the slope table builder
// Constants, the job record between front and back, and slope arithmetic.
// ----------------------------------------------------------------------------
package crst_pkg;

  // Table limits
  localparam int MIN_POINTS  = 4;
  localparam int MAX_POINTS  = 2048;
  localparam int MAX_FRAMES  = 256;
  localparam int QUEUE_DEPTH = 4;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int FRAME_W  = 8;
  localparam int ENTRY_W  = 12;
  localparam int POS_W    = 11;
  localparam int CB_W     = 4;
  localparam int FC_W     = 9;

  // Register map and reset values
  localparam logic REG_CYCLE_BITS  = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;
  localparam logic [CB_W-1:0] CYCLE_BITS_RESET  = 4'd11;
  localparam logic [FC_W-1:0] FRAME_COUNT_RESET = 9'd1;

  // Output slot within one job
  typedef enum logic [1:0] {
    SLOT_BODY,
    SLOT_LAST,
    SLOT_ZERO,
    SLOT_WRAP
  } slot_t;

  // One job: a body entry, and for the end of a cycle also the closing entries
  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic [POS_W-1:0]    base;        // entry index of the body entry
    logic [SAMPLE_W-1:0] body_value;
    logic [SAMPLE_W-1:0] body_slope;
    logic [SAMPLE_W-1:0] last_value;  // entry n-1
    logic [SAMPLE_W-1:0] last_slope;
    logic [SAMPLE_W-1:0] zero_value;  // entry 0 and wrap entry
    logic [SAMPLE_W-1:0] zero_slope;
    logic                wrap;        // job closes a cycle
    logic                table_last;  // cycle is the last frame
  } job_t;

  // floor((next - prev) / 2), exact in 25 bits
  function automatic logic [SAMPLE_W-1:0] half_diff(input logic [SAMPLE_W-1:0] next,
                                                    input logic [SAMPLE_W-1:0] prev);
    logic [SAMPLE_W:0] d;
    d = {next[SAMPLE_W-1], next} - {prev[SAMPLE_W-1], prev};
    return d[SAMPLE_W:1];
  endfunction

  // Cycle length 2^cycle_bits, clamped to the supported range
  function automatic logic [ENTRY_W-1:0] cycle_len(input logic [CB_W-1:0] cb);
    logic [ENTRY_W-1:0] n;
    if (cb < CB_W'($clog2(MIN_POINTS))) begin
      n = ENTRY_W'(MIN_POINTS);
    end else if (cb > CB_W'($clog2(MAX_POINTS))) begin
      n = ENTRY_W'(MAX_POINTS);
    end else begin
      n = ENTRY_W'(1) << cb;
    end
    return n;
  endfunction

  // Frames in use: zero counts as one, clamp at the maximum
  function automatic logic [FC_W-1:0] frames_used(input logic [FC_W-1:0] fc);
    logic [FC_W-1:0] f;
    if (fc == '0) begin
      f = FC_W'(1);
    end else if (fc > FC_W'(MAX_FRAMES)) begin
      f = FC_W'(MAX_FRAMES);
    end else begin
      f = fc;
    end
    return f;
  endfunction

endpackage

### hw/rtl/crst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crst_front: sample intake and classification
// Tracks position in the cycle and the sample history, and turns each sample
// from the third of each cycle on into a job for the back end.
// ----------------------------------------------------------------------------
module crst_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  input  logic [crst_pkg::SAMPLE_W-1:0] sample,
  input  logic                          queue_ready,
  input  logic [crst_pkg::CB_W-1:0]     cycle_bits,
  input  logic [crst_pkg::FC_W-1:0]     frame_count,
  input  logic                          cfg_write,
  output logic                          push,
  output crst_pkg::job_t                job
);

  logic [crst_pkg::SAMPLE_W-1:0] first_value;
  logic [crst_pkg::SAMPLE_W-1:0] second_value;
  logic [crst_pkg::SAMPLE_W-1:0] older_value;
  logic [crst_pkg::SAMPLE_W-1:0] newer_value;
  logic [crst_pkg::POS_W-1:0]    position;
  logic [crst_pkg::FRAME_W-1:0]  current_frame;

  logic [crst_pkg::ENTRY_W-1:0]  n;
  logic [crst_pkg::POS_W-1:0]    p;
  logic                          take;
  logic                          at_end;
  logic                          last_frame;
  logic [crst_pkg::POS_W-1:0]    position_next;
  logic [crst_pkg::FRAME_W-1:0]  frame_next;

  // Classify the incoming sample
  always_comb begin
    n          = crst_pkg::cycle_len(cycle_bits);
    p          = ({1'b0, position} >= n) ? '0 : position;
    take       = sample_valid && queue_ready;
    at_end     = ({1'b0, p} == (n - crst_pkg::ENTRY_W'(1)));
    last_frame = ({1'b0, current_frame} + crst_pkg::FC_W'(1)) >=
                 crst_pkg::frames_used(frame_count);
    position_next = at_end ? '0 : (p + crst_pkg::POS_W'(1));
    if (!at_end) begin
      frame_next = current_frame;
    end else if (last_frame) begin
      frame_next = '0;
    end else begin
      frame_next = current_frame + crst_pkg::FRAME_W'(1);
    end
  end

  // Job record; entries 0 and 1 give no result
  always_comb begin
    push            = take && (p >= crst_pkg::POS_W'(2));
    job.frame       = current_frame;
    job.base        = p - crst_pkg::POS_W'(1);
    job.body_value  = newer_value;
    job.body_slope  = crst_pkg::half_diff(sample, older_value);
    job.last_value  = sample;
    job.last_slope  = crst_pkg::half_diff(first_value, newer_value);
    job.zero_value  = first_value;
    job.zero_slope  = crst_pkg::half_diff(second_value, sample);
    job.wrap        = at_end;
    job.table_last  = last_frame;
  end

  // Sample history and position
  always_ff @(posedge clk) begin
    if (rst) begin
      first_value   <= '0;
      second_value  <= '0;
      older_value   <= '0;
      newer_value   <= '0;
      position      <= '0;
      current_frame <= '0;
    end else if (cfg_write) begin
      position      <= '0;
      current_frame <= '0;
    end else if (take) begin
      if (p == '0) begin
        first_value <= sample;
      end else begin
        older_value <= newer_value;
      end
      if (p == crst_pkg::POS_W'(1)) begin
        second_value <= sample;
      end
      newer_value   <= sample;
      position      <= position_next;
      current_frame <= frame_next;
    end
  end

endmodule

### hw/rtl/crst_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crst_queue: short job queue between front and back
// Circular buffer with a fill count; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module crst_queue #(
  parameter int DEPTH = crst_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  crst_pkg::job_t push_job,
  input  logic           pop,
  output crst_pkg::job_t head_job,
  output logic           not_full,
  output logic           not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crst_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_job  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/crst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crst_back: result sequencer
// Expands each job into one result, or four at the end of a cycle, and holds
// each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module crst_back (
  input  logic                          clk,
  input  logic                          rst,
  input  crst_pkg::job_t                head_job,
  input  logic                          job_valid,
  output logic                          pop,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [crst_pkg::FRAME_W-1:0]  frame_index,
  output logic [crst_pkg::ENTRY_W-1:0]  entry_index,
  output logic [crst_pkg::SAMPLE_W-1:0] value,
  output logic [crst_pkg::SAMPLE_W-1:0] slope,
  output logic                          frame_done,
  output logic                          table_done
);

  crst_pkg::slot_t slot;
  crst_pkg::slot_t slot_next;

  logic                          load;
  logic                          advance;
  logic                          job_end;
  logic [crst_pkg::ENTRY_W-1:0]  res_entry;
  logic [crst_pkg::SAMPLE_W-1:0] res_value;
  logic [crst_pkg::SAMPLE_W-1:0] res_slope;
  logic                          res_fdone;
  logic                          res_tdone;

  assign load    = !out_valid || out_ready;
  assign advance = load && job_valid;
  assign job_end = !head_job.wrap || (slot == crst_pkg::SLOT_WRAP);
  assign pop     = advance && job_end;

  // Next slot
  always_comb begin
    slot_next = slot;
    if (advance) begin
      unique case (slot)
        crst_pkg::SLOT_BODY: slot_next = head_job.wrap ? crst_pkg::SLOT_LAST
                                                       : crst_pkg::SLOT_BODY;
        crst_pkg::SLOT_LAST: slot_next = crst_pkg::SLOT_ZERO;
        crst_pkg::SLOT_ZERO: slot_next = crst_pkg::SLOT_WRAP;
        crst_pkg::SLOT_WRAP: slot_next = crst_pkg::SLOT_BODY;
        default:             slot_next = crst_pkg::SLOT_BODY;
      endcase
    end
  end

  // Result fields for the current slot
  always_comb begin
    res_fdone = 1'b0;
    res_tdone = 1'b0;
    unique case (slot)
      crst_pkg::SLOT_BODY: begin
        res_entry = {1'b0, head_job.base};
        res_value = head_job.body_value;
        res_slope = head_job.body_slope;
      end
      crst_pkg::SLOT_LAST: begin
        res_entry = {1'b0, head_job.base} + crst_pkg::ENTRY_W'(1);
        res_value = head_job.last_value;
        res_slope = head_job.last_slope;
      end
      crst_pkg::SLOT_ZERO: begin
        res_entry = '0;
        res_value = head_job.zero_value;
        res_slope = head_job.zero_slope;
      end
      crst_pkg::SLOT_WRAP: begin
        res_entry = {1'b0, head_job.base} + crst_pkg::ENTRY_W'(2);
        res_value = head_job.zero_value;
        res_slope = head_job.zero_slope;
        res_fdone = 1'b1;
        res_tdone = head_job.table_last;
      end
      default: begin
        res_entry = '0;
        res_value = '0;
        res_slope = '0;
      end
    endcase
  end

  // Slot register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= crst_pkg::SLOT_BODY;
    end else begin
      slot <= slot_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_index <= head_job.frame;
      entry_index <= res_entry;
      value       <= res_value;
      slope       <= res_slope;
      frame_done  <= res_fdone;
      table_done  <= res_tdone;
    end
  end

endmodule

### hw/rtl/catmull_rom_slope_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_slope_table: Catmull-Rom slope table builder
// Turns wavetable samples into table entries carrying value and slope, with
// a wrap entry closing each frame. Holds the configuration registers.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload
//  -------  ---------  --------------------------------------------------
//  s_*      in         sample
//  m_*      out        frame_index, entry_index, value, slope; tlast, tuser
//  apb      in/out     cycle_bits at 0x0, frame_count at 0x4
//
// Samples are taken one per cycle while the job queue has room. A sample
// yields no entry (first two of a cycle), one entry, or four entries (last of
// a cycle); the result sequencer sends one entry per cycle while the entry
// stream is ready, so a cycle of n samples yields n+1 entries and a long run
// at full rate makes the intake wait on the output.
// A job is queued at the edge that accepts its sample; its result is loaded
// into the output register once that job heads the queue and output has room.
// The four-deep job queue lets intake and output stall independently.
// Reset is synchronous; a register write restarts the table at frame 0.
// ----------------------------------------------------------------------------
module catmull_rom_slope_table #(
  parameter int QUEUE_DEPTH = crst_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] sample
  // table entry stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [7:0] frame_index, [19:8] entry_index,
                                 // [43:20] value, [67:44] slope, rest zero
  output logic        m_tlast,   // frame_done
  output logic        m_tuser,   // table_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [crst_pkg::CB_W-1:0] cycle_bits;
  logic [crst_pkg::FC_W-1:0] frame_count;
  logic                      cfg_write;

  logic                          push;
  logic                          pop;
  crst_pkg::job_t                push_job;
  crst_pkg::job_t                head_job;
  logic                          job_valid;
  logic [crst_pkg::FRAME_W-1:0]  frame_index;
  logic [crst_pkg::ENTRY_W-1:0]  entry_index;
  logic [crst_pkg::SAMPLE_W-1:0] value;
  logic [crst_pkg::SAMPLE_W-1:0] slope;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_bits  <= crst_pkg::CYCLE_BITS_RESET;
      frame_count <= crst_pkg::FRAME_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        crst_pkg::REG_CYCLE_BITS:  cycle_bits  <= pwdata[crst_pkg::CB_W-1:0];
        crst_pkg::REG_FRAME_COUNT: frame_count <= pwdata[crst_pkg::FC_W-1:0];
        default:                   cycle_bits  <= cycle_bits;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[2])
      crst_pkg::REG_CYCLE_BITS:  prdata = {{(32 - crst_pkg::CB_W){1'b0}}, cycle_bits};
      crst_pkg::REG_FRAME_COUNT: prdata = {{(32 - crst_pkg::FC_W){1'b0}}, frame_count};
      default:                   prdata = '0;
    endcase
  end

  crst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (s_tvalid),
    .sample       (s_tdata),
    .queue_ready  (s_tready),
    .cycle_bits   (cycle_bits),
    .frame_count  (frame_count),
    .cfg_write    (cfg_write),
    .push         (push),
    .job          (push_job)
  );

  crst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .not_full  (s_tready),
    .not_empty (job_valid)
  );

  crst_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .job_valid   (job_valid),
    .pop         (pop),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .frame_index (frame_index),
    .entry_index (entry_index),
    .value       (value),
    .slope       (slope),
    .frame_done  (m_tlast),
    .table_done  (m_tuser)
  );

  assign m_tdata = {4'b0, slope, value, entry_index, frame_index};

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for catmull_rom_slope_table
// Streams Q1.23 samples through the block under several cycle lengths and
// frame counts, predicts each table entry (value, slope, frame and entry
// index, done flags) and compares every output transfer in order. Both
// stream sides idle at random; settings change over APB only while idle.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [crst_pkg::FRAME_W-1:0]  frame;
    logic [crst_pkg::ENTRY_W-1:0]  entry;
    logic [crst_pkg::SAMPLE_W-1:0] value;
    logic [crst_pkg::SAMPLE_W-1:0] slope;
    logic                          frame_done;
    logic                          table_done;
  } table_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and expectations
  logic [crst_pkg::SAMPLE_W-1:0] samples_to_send[$];
  table_entry_t                  entries_due[$];

  // Predictor copy of the registers and the sample history
  logic [crst_pkg::CB_W-1:0]     cfg_cycle_bits = crst_pkg::CYCLE_BITS_RESET;
  logic [crst_pkg::FC_W-1:0]     cfg_frame_count = crst_pkg::FRAME_COUNT_RESET;
  logic [crst_pkg::SAMPLE_W-1:0] first_s = '0;
  logic [crst_pkg::SAMPLE_W-1:0] second_s = '0;
  logic [crst_pkg::SAMPLE_W-1:0] older_s = '0;
  logic [crst_pkg::SAMPLE_W-1:0] newer_s = '0;
  logic [crst_pkg::POS_W-1:0]    pos = '0;
  logic [crst_pkg::FRAME_W-1:0]  frame_no = '0;

  int  errors = 0;
  int  samples_sent = 0;
  int  entries_checked = 0;
  int  settings_used = 0;
  int  src_gap = 0;
  int  sink_gap = 0;
  bit  src_calm = 1'b0;
  bit  sink_calm = 1'b0;

  catmull_rom_slope_table i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // [23:0] sample
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),   // [7:0] frame, [19:8] entry, [43:20] value, [67:44] slope
    .m_tlast (m_tlast),   // frame_done
    .m_tuser (m_tuser),   // table_done
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Cycle length after clamping
  function automatic int points_for(input logic [crst_pkg::CB_W-1:0] cb);
    int n;
    n = 1 << cb;
    if (n < crst_pkg::MIN_POINTS) n = crst_pkg::MIN_POINTS;
    if (n > crst_pkg::MAX_POINTS) n = crst_pkg::MAX_POINTS;
    return n;
  endfunction

  function automatic int frames_for(input logic [crst_pkg::FC_W-1:0] fc);
    int f;
    f = int'(fc);
    if (f == 0) f = 1;
    if (f > crst_pkg::MAX_FRAMES) f = crst_pkg::MAX_FRAMES;
    return f;
  endfunction

  // floor((nxt - prv) / 2) from a 25-bit exact difference
  function automatic logic [crst_pkg::SAMPLE_W-1:0] slope_of(
      input logic [crst_pkg::SAMPLE_W-1:0] nxt,
      input logic [crst_pkg::SAMPLE_W-1:0] prv);
    logic signed [crst_pkg::SAMPLE_W:0] d;
    d = 25'(signed'(nxt)) - 25'(signed'(prv));
    return crst_pkg::SAMPLE_W'(d >>> 1);
  endfunction

  task automatic queue_entry(input int entry, input logic [crst_pkg::SAMPLE_W-1:0] value,
                             input logic [crst_pkg::SAMPLE_W-1:0] slope,
                             input logic fdone, input logic tdone);
    table_entry_t e;
    e.frame      = frame_no;
    e.entry      = crst_pkg::ENTRY_W'(entry);
    e.value      = value;
    e.slope      = slope;
    e.frame_done = fdone;
    e.table_done = tdone;
    entries_due.insert(entries_due.size(), e);
  endtask

  // Advance the table builder by one sample and queue the entries it yields
  task automatic fold_sample(input logic [crst_pkg::SAMPLE_W-1:0] s);
    int   n;
    int   p;
    logic last;
    n = points_for(cfg_cycle_bits);
    p = int'(pos);
    if (p >= n) p = 0;
    if (p == 0) begin
      first_s = s;
      newer_s = s;
    end else if (p == 1) begin
      second_s = s;
      older_s  = newer_s;
      newer_s  = s;
    end else begin
      queue_entry(p - 1, newer_s, slope_of(s, older_s), 1'b0, 1'b0);
      older_s = newer_s;
      newer_s = s;
    end
    // end of cycle: close with entry n-1, entry 0 and the wrap entry
    if (p == n - 1) begin
      last = (int'(frame_no) + 1 >= frames_for(cfg_frame_count));
      queue_entry(n - 1, s, slope_of(first_s, older_s), 1'b0, 1'b0);
      queue_entry(0, first_s, slope_of(second_s, s), 1'b0, 1'b0);
      queue_entry(n, first_s, slope_of(second_s, s), 1'b1, last);
      pos      = '0;
      frame_no = last ? '0 : frame_no + 1'b1;
    end else begin
      pos = crst_pkg::POS_W'(p + 1);
    end
  endtask

  // Mostly short gaps, a few long ones; calm stretches have none
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [crst_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      4: return crst_pkg::SAMPLE_W'($urandom_range(0, 32) - 16);
      default: return crst_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // Sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        fold_sample(s_tdata);
        samples_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          s_tdata  <= samples_to_send.pop_front();
          s_tvalid <= 1'b1;
          src_gap  = pick_gap(src_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Entry monitor and checker
  always @(posedge clk) begin
    table_entry_t got;
    table_entry_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.frame      = m_tdata[7:0];
        got.entry      = m_tdata[19:8];
        got.value      = m_tdata[43:20];
        got.slope      = m_tdata[67:44];
        got.frame_done = m_tlast;
        got.table_done = m_tuser;
        if (entries_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%t unexpected entry: frame %0d entry %0d value %h slope %h fd %b td %b",
                     $realtime, got.frame, got.entry, got.value, got.slope,
                     got.frame_done, got.table_done);
        end else begin
          want = entries_due.pop_front();
          entries_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%t entry mismatch", $realtime);
              $display("  expected frame %0d entry %0d value %h slope %h fd %b td %b",
                       want.frame, want.entry, want.value, want.slope,
                       want.frame_done, want.table_done);
              $display("  actual   frame %0d entry %0d value %h slope %h fd %b td %b",
                       got.frame, got.entry, got.value, got.slope,
                       got.frame_done, got.table_done);
            end
          end
        end
      end
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) sink_gap = pick_gap(sink_calm);
      end
    end
  end

  task automatic send(input logic [crst_pkg::SAMPLE_W-1:0] s);
    samples_to_send.insert(samples_to_send.size(), s);
  endtask

  // Block idle: nothing queued, nothing in flight, then a short pause for
  // samples that produce no entry but may still be in the pipeline
  task automatic wait_idle();
    while (samples_to_send.size() > 0 || s_tvalid || entries_due.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Setup then access cycle; the register takes the value at the access edge
  task automatic apb_write(input logic reg_sel, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == crst_pkg::REG_CYCLE_BITS) cfg_cycle_bits = data[crst_pkg::CB_W-1:0];
    else cfg_frame_count = data[crst_pkg::FC_W-1:0];
    pos      = '0;
    frame_no = '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Upper bits of the write data are junk the register must ignore
  task automatic configure(input logic [crst_pkg::CB_W-1:0] cb,
                           input logic [crst_pkg::FC_W-1:0] fc);
    wait_idle();
    apb_write(crst_pkg::REG_CYCLE_BITS, {28'($urandom), cb});
    apb_write(crst_pkg::REG_FRAME_COUNT, {23'($urandom), fc});
    settings_used++;
  endtask

  // Stimulus sequence
  initial begin
    int n;
    int count;
    int random_items;
    logic [crst_pkg::CB_W-1:0] cb;
    logic [crst_pkg::FC_W-1:0] fc;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings (2048 points, one frame): partial cycle with extreme
    // slopes both ways; the first two samples yield nothing
    send(24'h000000); send(24'h000000); send(24'h800000);
    send(24'h7FFFFF); send(24'h7FFFFF); send(24'h800000);
    send(24'h800000); send(24'hFFFFFF); send(24'h000001);

    // Cycle bits below range clamps to 4 points, zero frames counts as one;
    // each period after the first starts a new table
    configure(4'd0, 9'd0);
    send(24'h7FFFFF); send(24'h800000); send(24'h800000); send(24'h7FFFFF);
    send(24'h800000); send(24'h7FFFFF); send(24'h7FFFFF); send(24'h800000);

    // Above range on both registers; the next write cuts the cycle short
    configure(4'd15, 9'd511);
    repeat (5) send(rand_sample());
    configure(4'd1, 9'd257);
    send(24'h7FFFFF); send(24'h000000); send(24'h800000);

    // Random settings, mostly whole cycles, some cut short by a write
    random_items = 0;
    while (random_items < 345) begin
      cb = ($urandom_range(0, 9) == 0) ? crst_pkg::CB_W'($urandom_range(0, 15))
                                       : crst_pkg::CB_W'($urandom_range(2, 5));
      case ($urandom_range(0, 5))
        0: fc = 9'd0;
        1: fc = 9'd1;
        2: fc = crst_pkg::FC_W'($urandom_range(2, 4));
        3: fc = 9'd256;
        4: fc = crst_pkg::FC_W'($urandom_range(257, 511));
        default: fc = crst_pkg::FC_W'($urandom_range(1, 8));
      endcase
      configure(cb, fc);
      n = points_for(cb);
      if (n <= 32) begin
        count = n * $urandom_range(1, 4);
        if ($urandom_range(0, 2) == 0) count += $urandom_range(1, n - 1);
      end else begin
        count = $urandom_range(8, 40);
      end
      if (count > 345 - random_items) count = 345 - random_items;
      repeat (count) send(rand_sample());
      random_items += count;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Streamed %0d samples under %0d settings, checked %0d table entries.",
             samples_sent, settings_used + 1, entries_checked);
    $display("Mismatches or unexpected entries: %0d", errors);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d entries still due", entries_due.size());
    $display("tb failed");
    $finish;
  end

endmodule

### catmull_rom_slope_table.f
hw/rtl/crst_pkg.sv
hw/rtl/crst_front.sv
hw/rtl/crst_queue.sv
hw/rtl/crst_back.sv
hw/rtl/catmull_rom_slope_table.sv
tb/tb.sv
